[src/tcf_pkg.sv]
package tcf_pkg;

   localparam int CORDIC_ITERATIONS_DEF = 16;
   localparam int ITER_W                = 5;
   localparam int SQRT_STEPS            = 16;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND_WEIGHT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_TIME        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_GAIN       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_ROLL_ANGLE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_PITCH_ANGLE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_ROLL_RATE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_PITCH_RATE  = 3'd6;

   localparam logic [15:0]        BLEND_WEIGHT_RST     = 16'd64225;
   localparam logic [15:0]        STEP_TIME_RST        = 16'd131;
   localparam logic [19:0]        DRIVE_GAIN_RST       = 20'd445370;
   localparam logic signed [15:0] GAIN_ROLL_ANGLE_RST  = -16'sd4724;
   localparam logic signed [15:0] GAIN_PITCH_ANGLE_RST = -16'sd5580;
   localparam logic signed [15:0] GAIN_ROLL_RATE_RST   = -16'sd487;
   localparam logic signed [15:0] GAIN_PITCH_RATE_RST  = -16'sd578;

   // angle accumulator in 2^-20 degree
   localparam int ZW = 30;
   localparam logic signed [ZW-1:0] ANG_HALF_TURN = 30'sd188743680;

   // product selects for the shared multiplier
   localparam logic [3:0] MS_AYAY   = 4'd0;
   localparam logic [3:0] MS_AZAZ   = 4'd1;
   localparam logic [3:0] MS_RR_ST  = 4'd2;
   localparam logic [3:0] MS_ROLD   = 4'd3;
   localparam logic [3:0] MS_G_GAM  = 4'd4;
   localparam logic [3:0] MS_AROLL  = 4'd5;
   localparam logic [3:0] MS_RP_ST  = 4'd6;
   localparam logic [3:0] MS_POLD   = 4'd7;
   localparam logic [3:0] MS_APITCH = 4'd8;
   localparam logic [3:0] MS_LRA    = 4'd9;
   localparam logic [3:0] MS_LPA    = 4'd10;
   localparam logic [3:0] MS_LRR    = 4'd11;
   localparam logic [3:0] MS_LPR    = 4'd12;
   localparam logic [3:0] MS_E_DG   = 4'd13;

   localparam logic [1:0] ACC_NONE = 2'd0;
   localparam logic [1:0] ACC_LOAD = 2'd1;
   localparam logic [1:0] ACC_ADD  = 2'd2;
   localparam logic [1:0] ACC_SUB  = 2'd3;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_roll;
      logic signed [15:0] rate_pitch;
      logic signed [15:0] target_roll;
      logic signed [15:0] target_pitch;
      logic [15:0]        base_thrust;
   } tcf_req_type;

   typedef struct packed {
      logic [15:0]        motor_drive;
      logic signed [15:0] roll_estimate;
      logic signed [15:0] pitch_estimate;
      logic               drive_clipped;
   } tcf_rsp_type;

   typedef struct packed {
      logic              load_req;
      logic              mul_en;
      logic [3:0]        mul_sel;
      logic [1:0]        acc_op;
      logic              init_pitch;
      logic              init_roll;
      logic              cordic_step;
      logic              sqrt_step;
      logic [ITER_W-1:0] iter;
      logic              save_pitch_z;
      logic              save_roll_z;
      logic              save_roll;
      logic              save_pitch;
      logic              finish;
   } tcf_cmd_type;

   typedef struct packed {
      logic out_free;
   } tcf_status_type;

   function automatic logic signed [ZW-1:0] atan_entry(input logic [ITER_W-1:0] i);
      logic signed [ZW-1:0] v;
      case (i)
         5'd0:    v = 30'sd47185920;
         5'd1:    v = 30'sd27855475;
         5'd2:    v = 30'sd14718068;
         5'd3:    v = 30'sd7471121;
         5'd4:    v = 30'sd3750058;
         5'd5:    v = 30'sd1876857;
         5'd6:    v = 30'sd938658;
         5'd7:    v = 30'sd469357;
         5'd8:    v = 30'sd234682;
         5'd9:    v = 30'sd117342;
         5'd10:   v = 30'sd58671;
         5'd11:   v = 30'sd29335;
         5'd12:   v = 30'sd14668;
         5'd13:   v = 30'sd7334;
         5'd14:   v = 30'sd3667;
         5'd15:   v = 30'sd1833;
         5'd16:   v = 30'sd917;
         5'd17:   v = 30'sd458;
         5'd18:   v = 30'sd229;
         5'd19:   v = 30'sd115;
         5'd20:   v = 30'sd57;
         5'd21:   v = 30'sd29;
         5'd22:   v = 30'sd14;
         5'd23:   v = 30'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[src/tilt_complementary_filter_lqr.sv]
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   tcf_req_type (accel, gyro rates, targets, thrust)
// rsp_      out        rsp_valid/rsp_stall   tcf_rsp_type (drive, estimates, clip flag)
// csr_      in         csr_wen               csr_index, csr_wdata
//
// One request is in work at a time; its processing time is set by the two passes
// of the iterative CORDIC unit and the shared multiplier.
// The square root runs alongside the pitch CORDIC pass.
// Synchronous reset restores the register defaults and zeroes both angle estimates.
// A stalled result waits in the output register; the next request is taken meanwhile.
module tilt_complementary_filter_lqr import tcf_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tcf_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcf_rsp_type            rsp_data,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   tcf_cmd_type    cmd;
   tcf_status_type status;

   tcf_ctrl #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   tcf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while previous one in work");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in work");

   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.drive_clipped) |->
         (rsp_data.motor_drive == 16'hFFFF || rsp_data.motor_drive == 16'h0000))
      else $error("clip flag set with drive inside range");
`endif

endmodule

[src/tcf_ctrl.sv]
module tcf_ctrl import tcf_pkg::*; #(
   parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output tcf_cmd_type    cmd,
   input  tcf_status_type status
);

   localparam int LOOP_LEN = (CORDIC_ITERATIONS > SQRT_STEPS) ? CORDIC_ITERATIONS : SQRT_STEPS;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_SQ_A  = 5'd1;
   localparam logic [4:0] ST_SQ_B  = 5'd2;
   localparam logic [4:0] ST_SQ_C  = 5'd3;
   localparam logic [4:0] ST_PI    = 5'd4;
   localparam logic [4:0] ST_PRUN  = 5'd5;
   localparam logic [4:0] ST_PSAVE = 5'd6;
   localparam logic [4:0] ST_RI    = 5'd7;
   localparam logic [4:0] ST_RRUN  = 5'd8;
   localparam logic [4:0] ST_RSAVE = 5'd9;
   localparam logic [4:0] ST_B1    = 5'd10;
   localparam logic [4:0] ST_B2    = 5'd11;
   localparam logic [4:0] ST_B3    = 5'd12;
   localparam logic [4:0] ST_B4    = 5'd13;
   localparam logic [4:0] ST_B5    = 5'd14;
   localparam logic [4:0] ST_B6    = 5'd15;
   localparam logic [4:0] ST_B7    = 5'd16;
   localparam logic [4:0] ST_C2    = 5'd17;
   localparam logic [4:0] ST_C3    = 5'd18;
   localparam logic [4:0] ST_C4    = 5'd19;
   localparam logic [4:0] ST_C5    = 5'd20;
   localparam logic [4:0] ST_C6    = 5'd21;
   localparam logic [4:0] ST_C7    = 5'd22;
   localparam logic [4:0] ST_L2    = 5'd23;
   localparam logic [4:0] ST_L3    = 5'd24;
   localparam logic [4:0] ST_L4    = 5'd25;
   localparam logic [4:0] ST_L5    = 5'd26;
   localparam logic [4:0] ST_L6    = 5'd27;
   localparam logic [4:0] ST_L7    = 5'd28;
   localparam logic [4:0] ST_DONE  = 5'd29;

   logic [4:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      cmd.iter = iter_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_SQ_A;
            end
         end
         ST_SQ_A: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_AYAY;
            state_in    = ST_SQ_B;
         end
         ST_SQ_B: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_AZAZ;
            state_in    = ST_SQ_C;
         end
         ST_SQ_C: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_PI;
         end
         ST_PI: begin
            cmd.init_pitch = 1'b1;
            iter_in        = '0;
            state_in       = ST_PRUN;
         end
         ST_PRUN: begin
            // square root runs alongside the pitch angle
            cmd.sqrt_step   = (iter_ff < ITER_W'(SQRT_STEPS));
            cmd.cordic_step = (iter_ff < ITER_W'(CORDIC_ITERATIONS));
            iter_in         = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(LOOP_LEN - 1)) begin
               state_in = ST_PSAVE;
            end
         end
         ST_PSAVE: begin
            cmd.save_pitch_z = 1'b1;
            state_in         = ST_RI;
         end
         ST_RI: begin
            cmd.init_roll = 1'b1;
            iter_in       = '0;
            state_in      = ST_RRUN;
         end
         ST_RRUN: begin
            cmd.cordic_step = 1'b1;
            iter_in         = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(CORDIC_ITERATIONS - 1)) begin
               state_in = ST_RSAVE;
            end
         end
         ST_RSAVE: begin
            cmd.save_roll_z = 1'b1;
            state_in        = ST_B1;
         end
         ST_B1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_RR_ST;
            state_in    = ST_B2;
         end
         ST_B2: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_ROLD;
            state_in    = ST_B3;
         end
         ST_B3: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_B4;
         end
         ST_B4: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_G_GAM;
            state_in    = ST_B5;
         end
         ST_B5: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_AROLL;
            state_in    = ST_B6;
         end
         ST_B6: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_B7;
         end
         ST_B7: begin
            cmd.save_roll = 1'b1;
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MS_RP_ST;
            state_in      = ST_C2;
         end
         ST_C2: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_POLD;
            state_in    = ST_C3;
         end
         ST_C3: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_C4;
         end
         ST_C4: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_G_GAM;
            state_in    = ST_C5;
         end
         ST_C5: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_APITCH;
            state_in    = ST_C6;
         end
         ST_C6: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_C7;
         end
         ST_C7: begin
            cmd.save_pitch = 1'b1;
            cmd.mul_en     = 1'b1;
            cmd.mul_sel    = MS_LRA;
            state_in       = ST_L2;
         end
         ST_L2: begin
            cmd.acc_op  = ACC_LOAD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_LPA;
            state_in    = ST_L3;
         end
         ST_L3: begin
            cmd.acc_op  = ACC_ADD;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_LRR;
            state_in    = ST_L4;
         end
         ST_L4: begin
            cmd.acc_op  = ACC_SUB;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_LPR;
            state_in    = ST_L5;
         end
         ST_L5: begin
            cmd.acc_op = ACC_SUB;
            state_in   = ST_L6;
         end
         ST_L6: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MS_E_DG;
            state_in    = ST_L7;
         end
         ST_L7: begin
            cmd.acc_op = ACC_LOAD;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the result
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

endmodule

[src/tcf_dp.sv]
module tcf_dp import tcf_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  tcf_req_type            req_data,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  tcf_cmd_type            cmd,
   output tcf_status_type         status,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcf_rsp_type            rsp_data
);

   tcf_req_type req_ff;

   logic [15:0]        blend_ff, step_ff;
   logic [19:0]        dgain_ff;
   logic signed [15:0] gra_ff, gpa_ff, grr_ff, gpr_ff;

   logic signed [56:0] prod_ff;
   logic signed [57:0] acc_ff;

   logic signed [27:0]   cx_ff, cy_ff;
   logic signed [ZW-1:0] cz_ff;
   logic                 czero_ff;
   logic [31:0]          rem_ff, res_ff, bit_ff;

   logic signed [ZW-1:0] aroll_ff, apitch_ff;
   logic signed [15:0]   roll_ff, pitch_ff;

   tcf_rsp_type rsp_ff;
   logic        rsp_valid_ff;

   // ---------------- shared multiplier ----------------
   logic signed [35:0] mul_a;
   logic signed [20:0] mul_b;
   logic signed [56:0] mul_p;
   logic [16:0]        gam_c;
   logic signed [16:0] diff_r, diff_p;

   assign gam_c  = 17'h10000 - {1'b0, blend_ff};
   assign diff_r = $signed({req_ff.target_roll[15], req_ff.target_roll})
                 - $signed({roll_ff[15], roll_ff});
   assign diff_p = $signed({req_ff.target_pitch[15], req_ff.target_pitch})
                 - $signed({pitch_ff[15], pitch_ff});

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MS_AYAY: begin
            mul_a = 36'($signed(req_ff.accel_y));
            mul_b = 21'($signed(req_ff.accel_y));
         end
         MS_AZAZ: begin
            mul_a = 36'($signed(req_ff.accel_z));
            mul_b = 21'($signed(req_ff.accel_z));
         end
         MS_RR_ST: begin
            mul_a = 36'($signed(req_ff.rate_roll));
            mul_b = $signed({5'd0, step_ff});
         end
         MS_ROLD: begin
            mul_a = 36'(roll_ff);
            mul_b = 21'sd8192;
         end
         MS_G_GAM: begin
            mul_a = acc_ff[35:0];
            mul_b = $signed({5'd0, blend_ff});
         end
         MS_AROLL: begin
            mul_a = 36'(aroll_ff);
            mul_b = $signed({4'd0, gam_c});
         end
         MS_RP_ST: begin
            mul_a = 36'($signed(req_ff.rate_pitch));
            mul_b = $signed({5'd0, step_ff});
         end
         MS_POLD: begin
            mul_a = 36'(pitch_ff);
            mul_b = 21'sd8192;
         end
         MS_APITCH: begin
            mul_a = 36'(apitch_ff);
            mul_b = $signed({4'd0, gam_c});
         end
         MS_LRA: begin
            mul_a = 36'(diff_r);
            mul_b = 21'(gra_ff);
         end
         MS_LPA: begin
            mul_a = 36'(diff_p);
            mul_b = 21'(gpa_ff);
         end
         MS_LRR: begin
            mul_a = 36'($signed({req_ff.rate_roll, 3'b000}));
            mul_b = 21'(grr_ff);
         end
         MS_LPR: begin
            mul_a = 36'($signed({req_ff.rate_pitch, 3'b000}));
            mul_b = 21'(gpr_ff);
         end
         MS_E_DG: begin
            mul_a = acc_ff[35:0];
            mul_b = $signed({1'b0, dgain_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // ---------------- square root ----------------
   logic [32:0] sq_trial;
   assign sq_trial = {1'b0, res_ff} + {1'b0, bit_ff};

   // ---------------- CORDIC ----------------
   logic signed [16:0]   ci_x, ci_y, ci_xa, ci_ya;
   logic signed [ZW-1:0] ci_z;
   logic signed [27:0]   cxs, cys;
   logic signed [ZW-1:0] c_atan, cz_res;

   always_comb begin
      if (cmd.init_roll) begin
         ci_x = $signed({1'b0, res_ff[15:0]});
         ci_y = -$signed({req_ff.accel_x[15], req_ff.accel_x});
      end else begin
         ci_x = $signed({req_ff.accel_z[15], req_ff.accel_z});
         ci_y = $signed({req_ff.accel_y[15], req_ff.accel_y});
      end
      // turn a vector on the negative x side by half a turn first
      if (ci_x[16]) begin
         ci_xa = -ci_x;
         ci_ya = -ci_y;
         ci_z  = ci_y[16] ? -ANG_HALF_TURN : ANG_HALF_TURN;
      end else begin
         ci_xa = ci_x;
         ci_ya = ci_y;
         ci_z  = '0;
      end
   end

   assign cxs    = cx_ff >>> cmd.iter;
   assign cys    = cy_ff >>> cmd.iter;
   assign c_atan = atan_entry(cmd.iter);
   assign cz_res = czero_ff ? '0 : cz_ff;

   // ---------------- rounding and saturation ----------------
   logic signed [57:0] ang_rnd;
   logic signed [28:0] ang_q;
   logic signed [15:0] ang_sat;

   assign ang_rnd = acc_ff + 58'sd268435456;
   assign ang_q   = ang_rnd[57:29];

   always_comb begin
      if (ang_q > 29'sd32767) begin
         ang_sat = 16'sh7FFF;
      end else if (ang_q < -29'sd32768) begin
         ang_sat = 16'sh8000;
      end else begin
         ang_sat = ang_q[15:0];
      end
   end

   logic signed [57:0] eff_rnd;
   logic signed [36:0] effort;
   logic signed [37:0] drive;
   logic [15:0]        drive_sat;
   logic               drive_clip;

   assign eff_rnd = acc_ff + 58'sd1048576;
   assign effort  = eff_rnd[57:21];
   assign drive   = 38'(effort) + $signed({22'd0, req_ff.base_thrust});

   always_comb begin
      if (drive > 38'sd65535) begin
         drive_sat  = 16'hFFFF;
         drive_clip = 1'b1;
      end else if (drive < 38'sd0) begin
         drive_sat  = 16'h0000;
         drive_clip = 1'b1;
      end else begin
         drive_sat  = drive[15:0];
         drive_clip = 1'b0;
      end
   end

   // ---------------- control state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff     <= BLEND_WEIGHT_RST;
         step_ff      <= STEP_TIME_RST;
         dgain_ff     <= DRIVE_GAIN_RST;
         gra_ff       <= GAIN_ROLL_ANGLE_RST;
         gpa_ff       <= GAIN_PITCH_ANGLE_RST;
         grr_ff       <= GAIN_ROLL_RATE_RST;
         gpr_ff       <= GAIN_PITCH_RATE_RST;
         roll_ff      <= '0;
         pitch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_BLEND_WEIGHT:     blend_ff <= csr_wdata[15:0];
               CSR_STEP_TIME:        step_ff  <= csr_wdata[15:0];
               CSR_DRIVE_GAIN:       dgain_ff <= csr_wdata;
               CSR_GAIN_ROLL_ANGLE:  gra_ff   <= $signed(csr_wdata[15:0]);
               CSR_GAIN_PITCH_ANGLE: gpa_ff   <= $signed(csr_wdata[15:0]);
               CSR_GAIN_ROLL_RATE:   grr_ff   <= $signed(csr_wdata[15:0]);
               CSR_GAIN_PITCH_RATE:  gpr_ff   <= $signed(csr_wdata[15:0]);
               default: ;
            endcase
         end
         if (cmd.save_roll) begin
            roll_ff <= ang_sat;
         end
         if (cmd.save_pitch) begin
            pitch_ff <= ang_sat;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- payload ----------------
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.mul_en) begin
         prod_ff <= mul_p;
      end
      case (cmd.acc_op)
         ACC_LOAD: acc_ff <= 58'(prod_ff);
         ACC_ADD:  acc_ff <= acc_ff + 58'(prod_ff);
         ACC_SUB:  acc_ff <= acc_ff - 58'(prod_ff);
         default:  ;
      endcase
      if (cmd.init_pitch) begin
         rem_ff <= acc_ff[31:0];
         res_ff <= '0;
         bit_ff <= 32'h4000_0000;
      end else if (cmd.sqrt_step) begin
         if ({1'b0, rem_ff} >= sq_trial) begin
            rem_ff <= rem_ff - sq_trial[31:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.init_pitch || cmd.init_roll) begin
         cx_ff    <= $signed({{3{ci_xa[16]}}, ci_xa, 8'd0});
         cy_ff    <= $signed({{3{ci_ya[16]}}, ci_ya, 8'd0});
         cz_ff    <= ci_z;
         czero_ff <= (ci_x == 17'sd0) && (ci_y == 17'sd0);
      end else if (cmd.cordic_step) begin
         if (cy_ff[27]) begin
            cx_ff <= cx_ff - cys;
            cy_ff <= cy_ff + cxs;
            cz_ff <= cz_ff - c_atan;
         end else begin
            cx_ff <= cx_ff + cys;
            cy_ff <= cy_ff - cxs;
            cz_ff <= cz_ff + c_atan;
         end
      end
      if (cmd.save_pitch_z) begin
         apitch_ff <= cz_res;
      end
      if (cmd.save_roll_z) begin
         aroll_ff <= cz_res;
      end
      if (cmd.finish) begin
         rsp_ff.motor_drive    <= drive_sat;
         rsp_ff.roll_estimate  <= roll_ff;
         rsp_ff.pitch_estimate <= pitch_ff;
         rsp_ff.drive_clipped  <= drive_clip;
      end
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

endmodule
